FILE: src/oihp_pkg.sv
`timescale 1ns / 1ps
package oihp_pkg;

   localparam logic [63:0] MAGIC = "OpusHead";

   localparam logic [8:0] POS_MAX     = 9'd511;
   localparam logic [8:0] HEAD_LEN    = 9'd19;
   localparam logic [8:0] TABLE_START = 9'd21;
   localparam logic [7:0] SILENT      = 8'd255;
   localparam logic [7:0] FAM_VORBIS  = 8'd1;
   localparam logic [7:0] FAM_DISCRETE = 8'd255;

   localparam int QUEUE_DEPTH = 4;

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_NOT_HEAD    = 4'd1;
   localparam logic [3:0] ST_BAD_VERSION = 4'd2;
   localparam logic [3:0] ST_NO_CHANNELS = 4'd3;
   localparam logic [3:0] ST_FAM0_OVER   = 4'd4;
   localparam logic [3:0] ST_BAD_FAMILY  = 4'd5;
   localparam logic [3:0] ST_FAM1_OVER   = 4'd6;
   localparam logic [3:0] ST_TRUNCATED   = 4'd7;
   localparam logic [3:0] ST_LAYOUT      = 4'd8;
   localparam logic [3:0] ST_BAD_ENTRY   = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [3:0]         status;
      logic [7:0]         channel_index;
      logic [7:0]         mapping_value;
      logic [7:0]         version;
      logic [7:0]         channel_count;
      logic [15:0]        pre_skip;
      logic [31:0]        input_sample_rate;
      logic signed [15:0] output_gain;
      logic [7:0]         mapping_family;
      logic [7:0]         stream_count;
      logic [7:0]         coupled_count;
   } rsp_type;

   typedef struct packed {
      logic       emit_entry;
      logic [7:0] entry_ch;
      logic [7:0] entry_val;
      logic       emit_sum;
      logic [1:0] id_count;
      rsp_type    summary;
   } job_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      magic_byte = MAGIC[8 * (3'd7 - idx) +: 8];
   endfunction

   function automatic logic layout_bad(input logic [7:0] streams, input logic [7:0] coupled);
      logic [8:0] total;
      total = {1'b0, streams} + {1'b0, coupled};
      layout_bad = (streams == 8'd0) || (coupled > streams) || (total > 9'd255);
   endfunction

   function automatic logic [3:0] head_code(
      input logic       magic,
      input logic [9:0] len,
      input logic [7:0] version,
      input logic [7:0] channels,
      input logic [7:0] family,
      input logic [7:0] max_surround
   );
      if (!magic || len < {1'b0, HEAD_LEN}) begin
         head_code = ST_NOT_HEAD;
      end else if (version[7:4] != 4'd0) begin
         head_code = ST_BAD_VERSION;
      end else if (channels == 8'd0) begin
         head_code = ST_NO_CHANNELS;
      end else if (family == 8'd0) begin
         head_code = (channels > 8'd2) ? ST_FAM0_OVER : ST_OK;
      end else if (family != FAM_VORBIS && family != FAM_DISCRETE) begin
         head_code = ST_BAD_FAMILY;
      end else if (family == FAM_VORBIS && channels > max_surround) begin
         head_code = ST_FAM1_OVER;
      end else begin
         head_code = ST_OK;
      end
   endfunction

endpackage

FILE: src/oihp_front.sv
`timescale 1ns / 1ps
module oihp_front #(
   parameter int MAX_SURROUND_CHANNELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  oihp_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             push,
   output oihp_pkg::job_type push_job
);

   localparam logic [7:0] MaxSurround = 8'(MAX_SURROUND_CHANNELS);

   logic        accept;
   logic [8:0]  pos_ff, pos_in, pos_sat;
   logic        magic_ff, magic_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  channels_ff, channels_in;
   logic [15:0] pre_skip_ff, pre_skip_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] gain_ff, gain_in;
   logic [7:0]  family_ff, family_in;
   logic [7:0]  streams_ff, streams_in;
   logic [7:0]  coupled_ff, coupled_in;
   logic        entry_error_ff, entry_error_in;
   logic [8:0]  ch_off;
   logic [8:0]  stream_total;
   logic [9:0]  len;
   logic [3:0]  status;
   logic        table_open;

   assign accept = req_valid && !queue_full;

   always_comb begin
      magic_in       = magic_ff;
      version_in     = version_ff;
      channels_in    = channels_ff;
      pre_skip_in    = pre_skip_ff;
      rate_in        = rate_ff;
      gain_in        = gain_ff;
      family_in      = family_ff;
      streams_in     = streams_ff;
      coupled_in     = coupled_ff;
      entry_error_in = entry_error_ff;
      push_job       = '0;
      ch_off         = pos_ff - oihp_pkg::TABLE_START;
      stream_total   = {1'b0, streams_ff} + {1'b0, coupled_ff};
      table_open     = (ch_off < {1'b0, channels_ff}) && (family_ff != 8'd0)
                       && (oihp_pkg::head_code(magic_ff, {1'b0, pos_ff}, version_ff,
                                               channels_ff, family_ff, MaxSurround)
                           == oihp_pkg::ST_OK)
                       && !oihp_pkg::layout_bad(streams_ff, coupled_ff)
                       && !entry_error_ff;

      unique case (pos_ff) inside
         [9'd0:9'd7]: begin
            if (req_data.data_byte != oihp_pkg::magic_byte(pos_ff[2:0])) begin
               magic_in = 1'b0;
            end
         end
         9'd8: begin
            version_in = req_data.data_byte;
         end
         9'd9: begin
            channels_in = req_data.data_byte;
         end
         [9'd10:9'd11]: begin
            pre_skip_in[8 * pos_ff[0] +: 8] = req_data.data_byte;
         end
         [9'd12:9'd15]: begin
            rate_in[8 * pos_ff[1:0] +: 8] = req_data.data_byte;
         end
         [9'd16:9'd17]: begin
            gain_in[8 * pos_ff[0] +: 8] = req_data.data_byte;
         end
         9'd18: begin
            family_in = req_data.data_byte;
         end
         9'd19: begin
            streams_in = req_data.data_byte;
         end
         9'd20: begin
            coupled_in = req_data.data_byte;
         end
         default: begin
            if (table_open) begin
               if (req_data.data_byte != oihp_pkg::SILENT
                   && {1'b0, req_data.data_byte} >= stream_total) begin
                  entry_error_in = 1'b1;
               end else begin
                  push_job.emit_entry = 1'b1;
                  push_job.entry_ch   = ch_off[7:0];
                  push_job.entry_val  = req_data.data_byte;
               end
            end
         end
      endcase

      pos_sat = (pos_ff == oihp_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
      len     = {1'b0, pos_sat};
      status  = oihp_pkg::head_code(magic_in, len, version_in, channels_in, family_in,
                                    MaxSurround);
      if (status == oihp_pkg::ST_OK && family_in != 8'd0) begin
         if (len < {1'b0, oihp_pkg::TABLE_START} + {2'b00, channels_in}) begin
            status = oihp_pkg::ST_TRUNCATED;
         end else if (oihp_pkg::layout_bad(streams_in, coupled_in)) begin
            status = oihp_pkg::ST_LAYOUT;
         end else if (entry_error_in) begin
            status = oihp_pkg::ST_BAD_ENTRY;
         end
      end

      push_job.emit_sum                  = req_data.last_byte;
      push_job.summary.kind              = oihp_pkg::KIND_SUMMARY;
      push_job.summary.status            = status;
      push_job.summary.version           = version_in;
      push_job.summary.channel_count     = channels_in;
      push_job.summary.pre_skip          = pre_skip_in;
      push_job.summary.input_sample_rate = rate_in;
      push_job.summary.output_gain       = gain_in;
      push_job.summary.mapping_family    = family_in;
      push_job.summary.stream_count      = streams_in;
      push_job.summary.coupled_count     = coupled_in;
      if (status == oihp_pkg::ST_OK && family_in == 8'd0) begin
         push_job.id_count                = channels_in[1:0];
         push_job.summary.stream_count    = 8'd1;
         push_job.summary.coupled_count   = (channels_in == 8'd2) ? 8'd1 : 8'd0;
      end

      pos_in = pos_sat;
   end

   assign push = accept && (push_job.emit_entry || req_data.last_byte);

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_byte)) begin
         pos_ff         <= '0;
         magic_ff       <= 1'b1;
         version_ff     <= '0;
         channels_ff    <= '0;
         pre_skip_ff    <= '0;
         rate_ff        <= '0;
         gain_ff        <= '0;
         family_ff      <= '0;
         streams_ff     <= '0;
         coupled_ff     <= '0;
         entry_error_ff <= 1'b0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         magic_ff       <= magic_in;
         version_ff     <= version_in;
         channels_ff    <= channels_in;
         pre_skip_ff    <= pre_skip_in;
         rate_ff        <= rate_in;
         gain_ff        <= gain_in;
         family_ff      <= family_in;
         streams_ff     <= streams_in;
         coupled_ff     <= coupled_in;
         entry_error_ff <= entry_error_in;
      end
   end

endmodule

FILE: src/oihp_queue.sv
`timescale 1ns / 1ps
module oihp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  oihp_pkg::job_type push_job,
   output logic              full,
   output logic              head_valid,
   output oihp_pkg::job_type head_job,
   input  logic              pop
);

   localparam int PtrWidth = $clog2(oihp_pkg::QUEUE_DEPTH);
   localparam int CntWidth = $clog2(oihp_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntWidth-1:0] Depth = CntWidth'(oihp_pkg::QUEUE_DEPTH);

   oihp_pkg::job_type    mem_ff [oihp_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  count_ff, count_in;

   assign full       = (count_ff == Depth);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/oihp_back.sv
`timescale 1ns / 1ps
module oihp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  oihp_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output oihp_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   oihp_pkg::rsp_type rsp_data_ff;
   oihp_pkg::rsp_type item;
   logic [1:0]        step_ff, step_in;
   logic [1:0]        total;
   logic [1:0]        entries;
   logic              load;

   always_comb begin
      entries = {1'b0, head_job.emit_entry} + head_job.id_count;
      total   = entries + {1'b0, head_job.emit_sum};
      load    = head_valid && (!rsp_valid_ff || !rsp_stall);
      pop     = load && (step_ff == total - 2'd1);

      item      = '0;
      item.kind = oihp_pkg::KIND_ENTRY;
      if (head_job.emit_entry) begin
         item.channel_index = head_job.entry_ch;
         item.mapping_value = head_job.entry_val;
      end else begin
         item.channel_index = {6'd0, step_ff};
         item.mapping_value = {6'd0, step_ff};
      end
      if (step_ff >= entries) begin
         item = head_job.summary;
      end

      if (pop) begin
         step_in = 2'd0;
      end else if (load) begin
         step_in = step_ff + 2'd1;
      end else begin
         step_in = step_ff;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/opus_id_header_parser_unit.sv
`timescale 1ns / 1ps
// A req transfer reaches its first rsp item via the queue write, then the output register.
// Throughput, rsp_stall low: one byte per cycle while each byte yields at most one rsp item;
//   a family 0 packet's last byte yields up to 3 items, drained one per cycle by the back end.
// A 4-entry job queue between parser front end and output back end absorbs those bursts.
// Reset is synchronous, active high: clears parse state, queue and rsp_valid.
module opus_id_header_parser_unit #(
   parameter int MAX_SURROUND_CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  oihp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output oihp_pkg::rsp_type rsp_data
);

   logic              push;
   oihp_pkg::job_type push_job;
   logic              full;
   logic              head_valid;
   oihp_pkg::job_type head_job;
   logic              pop;

   assign req_stall = full;

   oihp_front #(
      .MAX_SURROUND_CHANNELS(MAX_SURROUND_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   oihp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   oihp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: test/opus_head_checker.sv
`timescale 1ns / 1ps
module opus_head_checker #(
   parameter int MAX_SURROUND_CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  oihp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  oihp_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                outstanding,
   output int                entries_checked,
   output int                summaries_checked,
   output logic [15:0]       status_seen
);
   import oihp_pkg::*;

   logic [8:0]  byte_pos;
   logic        magic_ok;
   logic [7:0]  version_b;
   logic [7:0]  channels_b;
   logic [7:0]  family_b;
   logic [7:0]  streams_b;
   logic [7:0]  coupled_b;
   logic [15:0] pre_skip_b;
   logic [15:0] gain_b;
   logic [31:0] rate_b;
   logic        entry_failed;
   rsp_type     awaited_items[$];

   task automatic clear_header();
      byte_pos     = '0;
      magic_ok     = 1'b1;
      version_b    = '0;
      channels_b   = '0;
      family_b     = '0;
      streams_b    = '0;
      coupled_b    = '0;
      pre_skip_b   = '0;
      gain_b       = '0;
      rate_b       = '0;
      entry_failed = 1'b0;
   endtask

   function automatic logic [3:0] header_status(input int unsigned len);
      if (!magic_ok || len < HEAD_LEN) return ST_NOT_HEAD;
      if (version_b[7:4] != 4'd0) return ST_BAD_VERSION;
      if (channels_b == 8'd0) return ST_NO_CHANNELS;
      if (family_b == 8'd0) return (channels_b > 8'd2) ? ST_FAM0_OVER : ST_OK;
      if (family_b != FAM_VORBIS && family_b != FAM_DISCRETE) return ST_BAD_FAMILY;
      if (family_b == FAM_VORBIS && int'(channels_b) > MAX_SURROUND_CHANNELS) begin
         return ST_FAM1_OVER;
      end
      return ST_OK;
   endfunction

   function automatic logic layout_broken();
      int total;
      total = int'(streams_b) + int'(coupled_b);
      return streams_b == 8'd0 || coupled_b > streams_b || total > 255;
   endfunction

   task automatic expect_entry(input int ch, input logic [7:0] val);
      rsp_type e;
      e = '0;
      e.kind          = KIND_ENTRY;
      e.status        = ST_OK;
      e.channel_index = ch[7:0];
      e.mapping_value = val;
      awaited_items.push_back(e);
   endtask

   task automatic parse_byte(input req_type r);
      int unsigned p;
      int unsigned len;
      int          total;
      rsp_type     s;
      p = 32'(byte_pos);
      total = int'(streams_b) + int'(coupled_b);
      if (p < 8) begin
         if (r.data_byte != MAGIC[63 - 8 * p -: 8]) magic_ok = 1'b0;
      end else if (p == 8) begin
         version_b = r.data_byte;
      end else if (p == 9) begin
         channels_b = r.data_byte;
      end else if (p <= 11) begin
         pre_skip_b[8 * (p - 10) +: 8] = r.data_byte;
      end else if (p <= 15) begin
         rate_b[8 * (p - 12) +: 8] = r.data_byte;
      end else if (p <= 17) begin
         gain_b[8 * (p - 16) +: 8] = r.data_byte;
      end else if (p == 18) begin
         family_b = r.data_byte;
      end else if (p == 19) begin
         streams_b = r.data_byte;
      end else if (p == 20) begin
         coupled_b = r.data_byte;
      end else if (p - TABLE_START < channels_b && family_b != 8'd0 &&
                   header_status(p + 1) == ST_OK && !layout_broken() && !entry_failed) begin
         if (r.data_byte != SILENT && int'(r.data_byte) >= total) begin
            entry_failed = 1'b1;
         end else begin
            expect_entry(p - TABLE_START, r.data_byte);
         end
      end

      if (byte_pos != POS_MAX) byte_pos++;

      if (r.last_byte) begin
         len = 32'(byte_pos);
         s = '0;
         s.kind          = KIND_SUMMARY;
         s.status        = header_status(len);
         s.stream_count  = streams_b;
         s.coupled_count = coupled_b;
         if (s.status == ST_OK && family_b != 8'd0) begin
            if (len < TABLE_START + channels_b) s.status = ST_TRUNCATED;
            else if (layout_broken()) s.status = ST_LAYOUT;
            else if (entry_failed) s.status = ST_BAD_ENTRY;
         end else if (s.status == ST_OK) begin
            // family 0: identity table goes out ahead of the summary
            for (int ch = 0; ch < channels_b; ch++) expect_entry(ch, ch[7:0]);
            s.stream_count  = 8'd1;
            s.coupled_count = (channels_b == 8'd2) ? 8'd1 : 8'd0;
         end
         s.version           = version_b;
         s.channel_count     = channels_b;
         s.pre_skip          = pre_skip_b;
         s.input_sample_rate = rate_b;
         s.output_gain       = gain_b;
         s.mapping_family    = family_b;
         awaited_items.push_back(s);
         clear_header();
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_items.size() == 0) begin
         report_mismatch($sformatf("result %h arrived with nothing pending", got));
      end else begin
         want = awaited_items.pop_front();
         compare_field("kind", 32'(got.kind), 32'(want.kind));
         compare_field("status", 32'(got.status), 32'(want.status));
         compare_field("channel_index", 32'(got.channel_index), 32'(want.channel_index));
         compare_field("mapping_value", 32'(got.mapping_value), 32'(want.mapping_value));
         compare_field("version", 32'(got.version), 32'(want.version));
         compare_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
         compare_field("pre_skip", 32'(got.pre_skip), 32'(want.pre_skip));
         compare_field("input_sample_rate", got.input_sample_rate,
                       want.input_sample_rate);
         compare_field("output_gain", 32'(got.output_gain), 32'(want.output_gain));
         compare_field("mapping_family", 32'(got.mapping_family),
                       32'(want.mapping_family));
         compare_field("stream_count", 32'(got.stream_count), 32'(want.stream_count));
         compare_field("coupled_count", 32'(got.coupled_count), 32'(want.coupled_count));
         if (want.kind == KIND_SUMMARY) begin
            summaries_checked++;
            status_seen[want.status] = 1'b1;
         end else begin
            entries_checked++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_header();
         awaited_items.delete();
         mismatch_count    = 0;
         entries_checked   = 0;
         summaries_checked = 0;
         status_seen       = '0;
      end else begin
         if (req_valid && !req_stall) parse_byte(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      outstanding <= awaited_items.size();
   end

endmodule

FILE: test/opus_id_header_parser_unit_tb.sv
`timescale 1ns / 1ps
module opus_id_header_parser_unit_tb;
   import oihp_pkg::*;

   localparam int         SURROUND_LIMIT = 8;
   localparam int         HOLD_CYCLES    = 100;
   localparam int         QUIET_LIMIT    = 1000;
   localparam int         DRAIN_CYCLES   = 10;
   localparam int         ITEM_TARGET    = 230;
   localparam int         LONG_EXTRA     = 2;
   localparam logic [7:0] LONG_CHANNELS  = 8'd32;

   typedef enum int {
      PK_OK_FAM0, PK_OK_FAM1, PK_OK_DISCRETE, PK_SHORT, PK_BAD_MAGIC, PK_BAD_VERSION,
      PK_NO_CHANNELS, PK_FAM0_OVER, PK_BAD_FAMILY, PK_FAM1_OVER, PK_TRUNCATED,
      PK_LAYOUT, PK_BAD_ENTRY, PK_NOISE, PK_KINDS
   } packet_kind_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int          mismatch_count;
   int          outstanding;
   int          entries_checked;
   int          summaries_checked;
   logic [15:0] status_seen;

   int         idle_pct        = 0;
   int         stall_pct       = 0;
   logic       pressure_on     = 1'b0;
   logic       pressure_served = 1'b0;
   int         hold_left       = 0;
   int         quiet_cycles    = 0;
   int         bytes_sent      = 0;
   int         packets_sent    = 0;
   logic [7:0] packet[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   opus_id_header_parser_unit #(
      .MAX_SURROUND_CHANNELS(SURROUND_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   opus_head_checker #(
      .MAX_SURROUND_CHANNELS(SURROUND_LIMIT)
   ) head_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .entries_checked  (entries_checked),
      .summaries_checked(summaries_checked),
      .status_seen      (status_seen)
   );

   // hold off the output once for a long stretch, otherwise stall at random
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pressure_on && !pressure_served) begin
         rsp_stall       <= 1'b1;
         hold_left       <= HOLD_CYCLES - 1;
         pressure_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No transfer for %0d cycles, %0d results still pending",
                  QUIET_LIMIT, outstanding);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_type next_req;
      next_req.data_byte = b;
      next_req.last_byte = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= next_req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet.size(); i++) send_byte(packet[i], i == packet.size() - 1);
      bytes_sent += packet.size();
      packets_sent++;
   endtask

   task automatic build_packet(input logic [7:0] ver, chans, fam, st, cp,
                               input int bad_slot, extra, cut, corrupt_at);
      logic [15:0] skip;
      logic [31:0] rate;
      logic [15:0] gain;
      int          total;
      skip  = 16'($urandom);
      rate  = $urandom;
      gain  = 16'($urandom);
      total = int'(st) + int'(cp);
      packet.delete();
      for (int i = 0; i < 8; i++) packet.push_back(MAGIC[63 - 8 * i -: 8]);
      packet.push_back(ver);
      packet.push_back(chans);
      for (int i = 0; i < 2; i++) packet.push_back(skip[8 * i +: 8]);
      for (int i = 0; i < 4; i++) packet.push_back(rate[8 * i +: 8]);
      for (int i = 0; i < 2; i++) packet.push_back(gain[8 * i +: 8]);
      packet.push_back(fam);
      if (fam != 8'd0) begin
         packet.push_back(st);
         packet.push_back(cp);
         for (int c = 0; c < chans; c++) begin
            if (c == bad_slot) packet.push_back(8'($urandom_range(total, 254)));
            else if (total == 0 || $urandom_range(3) == 0) packet.push_back(SILENT);
            else packet.push_back(8'($urandom_range(0, total - 1)));
         end
      end
      repeat (extra) packet.push_back(8'($urandom_range(0, 255)));
      if (corrupt_at >= 0) begin
         packet[corrupt_at] = packet[corrupt_at] ^ 8'($urandom_range(1, 255));
      end
      while (cut > 0 && packet.size() > cut) void'(packet.pop_back());
   endtask

   task automatic make_packet(input packet_kind_type kind);
      logic [7:0] ver;
      logic [7:0] chans;
      logic [7:0] fam;
      logic [7:0] st;
      logic [7:0] cp;
      int         bad_slot;
      int         extra;
      int         cut;
      int         corrupt_at;
      ver        = 8'($urandom_range(0, 15));
      chans      = 8'($urandom_range(1, 8));
      fam        = ($urandom_range(1) == 0) ? FAM_VORBIS : FAM_DISCRETE;
      st         = 8'($urandom_range(1, 8));
      cp         = 8'($urandom_range(0, st));
      bad_slot   = -1;
      extra      = $urandom_range(0, 2);
      cut        = 0;
      corrupt_at = -1;
      case (kind)
         PK_OK_FAM0: begin
            fam   = 8'd0;
            chans = 8'($urandom_range(1, 2));
         end
         PK_OK_FAM1: fam = FAM_VORBIS;
         PK_OK_DISCRETE: begin
            fam   = FAM_DISCRETE;
            chans = 8'($urandom_range(1, 12));
            st    = 8'($urandom_range(1, 127));
            cp    = 8'($urandom_range(0, st));
         end
         PK_SHORT: cut = $urandom_range(1, 18);
         PK_BAD_MAGIC: corrupt_at = $urandom_range(0, 7);
         PK_BAD_VERSION: ver = 8'($urandom_range(16, 255));
         PK_NO_CHANNELS: begin
            chans = 8'd0;
            if ($urandom_range(2) == 0) fam = 8'd0;
         end
         PK_FAM0_OVER: begin
            fam   = 8'd0;
            chans = 8'($urandom_range(3, 255));
         end
         PK_BAD_FAMILY: fam = 8'($urandom_range(2, 254));
         PK_FAM1_OVER: begin
            fam   = FAM_VORBIS;
            chans = 8'($urandom_range(9, 255));
            cut   = $urandom_range(19, 32);
         end
         PK_TRUNCATED: begin
            chans = 8'($urandom_range(2, 8));
            cut   = $urandom_range(19, 20 + chans);
         end
         PK_LAYOUT: begin
            case ($urandom_range(2))
               0: st = 8'd0;
               1: begin
                  st = 8'($urandom_range(1, 127));
                  cp = 8'($urandom_range(st + 1, 255));
               end
               default: begin
                  st = 8'($urandom_range(128, 255));
                  cp = 8'($urandom_range(256 - st, st));
               end
            endcase
         end
         PK_BAD_ENTRY: bad_slot = $urandom_range(0, chans - 1);
         default: ;
      endcase
      build_packet(ver, chans, fam, st, cp, bad_slot, extra, cut, corrupt_at);
      if (kind == PK_NOISE) begin
         packet.delete();
         repeat ($urandom_range(1, 30)) packet.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic set_idling(input int phase);
      case (phase)
         0: begin
            idle_pct = 0;
            stall_pct <= 0;
         end
         1: begin
            idle_pct = 46;
            stall_pct <= 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct <= 46;
         end
         default: begin
            idle_pct = 15;
            stall_pct <= 15;
         end
      endcase
   endtask

   // discrete table with a full stream range, sent while the output is held off
   task automatic send_long_packet();
      idle_pct = 0;
      stall_pct <= 0;
      pressure_on <= 1'b1;
      build_packet(8'h01, LONG_CHANNELS, FAM_DISCRETE, 8'd200, 8'd55, -1, LONG_EXTRA, 0, -1);
      send_packet();
      pressure_on <= 1'b0;
   endtask

   initial begin
      int kind_idx;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      packet.delete();
      packet.push_back(8'h00);
      send_packet();
      packet.delete();
      packet.push_back(8'hFF);
      send_packet();
      build_packet(8'h0F, 8'd2, 8'd0, 8'd0, 8'd0, -1, 0, 0, -1);
      for (int i = 10; i < 16; i++) packet[i] = 8'hFF;
      packet[16] = 8'h00;
      packet[17] = 8'h80;
      send_packet();

      kind_idx = 0;
      while (kind_idx < PK_KINDS || bytes_sent < ITEM_TARGET) begin
         if (kind_idx == 6) send_long_packet();
         set_idling(kind_idx % 4);
         make_packet(packet_kind_type'(kind_idx % PK_KINDS));
         send_packet();
         kind_idx++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d packets, one of them against a %0d-cycle output hold-off",
               bytes_sent, packets_sent, HOLD_CYCLES);
      $display("Checked %0d mapping entries and %0d summaries, status codes seen %b",
               entries_checked, summaries_checked, status_seen[9:0]);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/oihp_pkg.sv
src/oihp_front.sv
src/oihp_queue.sv
src/oihp_back.sv
src/opus_id_header_parser_unit.sv
test/opus_head_checker.sv
test/opus_id_header_parser_unit_tb.sv
